>>> hw/rtl/ifri_pkg.sv
`default_nettype none

package ifri_pkg;

    localparam int MAX_DIMENSION = 256;
    localparam int CHANNEL_BITS  = 8;

    // Fixed widths of the stream and register fields.
    localparam int FIELD_W    = 8;
    localparam int DIM_REG_W  = 9;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int DIM_W       = $clog2(MAX_DIMENSION + 1);
    localparam int STORE_DEPTH = MAX_DIMENSION * MAX_DIMENSION;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LOAD_W      = $clog2(STORE_DEPTH + 1);
    localparam int PIX_W       = 3 * CHANNEL_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE     = 3'd4;

    localparam logic [MODE_W-1:0] MODE_INVERT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR_V = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_LEFT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_RIGHT = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [DIM_REG_W-1:0] DIM_RESET      = 9'd256;
    localparam logic [MODE_W-1:0]    MODE_RESET     = 3'd0;
    localparam logic [FIELD_W-1:0]   MAX_VAL_RESET  = 8'd255;
    localparam logic                 COLOR_RESET    = 1'b0;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] max_value;
        logic               color_rgb;
    } ifri_cfg_t;

    // A dimension of zero acts as one, any value above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] raw);
        logic [DIM_W-1:0] res;
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (32'(raw) > MAX_DIMENSION) begin
            res = DIM_W'(MAX_DIMENSION);
        end else begin
            res = DIM_W'(raw);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/image_flip_rotate_invert.sv
// Image orientation engine built around a single frame buffer.
// Input stream (s_*): s_tuser selects the operation. A load word writes the
// next pixel of the frame in raster order; loads beyond the frame size are
// dropped. A fetch word returns the next pixel of the transformed frame on
// the output stream (m_*) with m_tlast on the final pixel, after which a new
// frame must be loaded. A fetch made before the frame is complete is dropped.
// Configuration (cfg_*): always ready; writes are to be made while the block
// is idle, which the block does not enforce. Writing the width or height restarts the frame.
// A load is written to the frame buffer as it is accepted. A fetch latches
// its source coordinate when accepted, then reads the frame buffer at the
// multiplied address (ST_ADDR), then registers the formatted pixel
// (ST_READ). The frame buffer has a single read and a single write port
// and a fetch holds the input until its pixel is formatted, so no new word
// is taken while a fetch is in progress.
// A waiting result does not block the next word; a fetch that finishes while
// the receiver still stalls holds until the output register frees.
// Reset restores the register defaults and empties the frame; the buffer
// contents are left as they are.
`default_nettype none

module image_flip_rotate_invert (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [3*ifri_pkg::FIELD_W-1:0]     s_tdata,  // in_red, in_green, in_blue
    input  wire logic                               s_tuser,  // operation
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [3*ifri_pkg::FIELD_W-1:0]     m_tdata,  // out_red, out_green, out_blue
    output      logic                               m_tlast,  // last_pixel
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [ifri_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ifri_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ifri_pkg::ifri_cfg_t               cfg;
    logic                              restart;
    logic                              ram_we, ram_re;
    logic [ifri_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [ifri_pkg::PIX_W-1:0]        ram_wdata, ram_rdata;

    ifri_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    ifri_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .restart   (restart),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ifri_ram #(
        .WIDTH (ifri_pkg::PIX_W),
        .DEPTH (ifri_pkg::STORE_DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ifri_ram.sv
`default_nettype none

module ifri_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ifri_regs.sv
`default_nettype none

module ifri_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [ifri_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ifri_pkg::CFG_DATA_W-1:0]    cfg_data,
    output      ifri_pkg::ifri_cfg_t                cfg,
    output      logic                               restart
);

    logic [ifri_pkg::DIM_REG_W-1:0] width_reg, width_next;
    logic [ifri_pkg::DIM_REG_W-1:0] height_reg, height_next;
    logic [ifri_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [ifri_pkg::FIELD_W-1:0]   maxv_reg, maxv_next;
    logic                           color_reg, color_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        maxv_next   = maxv_reg;
        color_next  = color_reg;
        restart     = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                ifri_pkg::REG_IMAGE_WIDTH: begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                ifri_pkg::REG_IMAGE_HEIGHT: begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                ifri_pkg::REG_TRANSFORM_MODE: mode_next = cfg_data[ifri_pkg::MODE_W-1:0];
                ifri_pkg::REG_MAX_VALUE:      maxv_next = cfg_data[ifri_pkg::FIELD_W-1:0];
                ifri_pkg::REG_COLOR_MODE:     color_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ifri_pkg::DIM_RESET;
            height_reg <= ifri_pkg::DIM_RESET;
            mode_reg   <= ifri_pkg::MODE_RESET;
            maxv_reg   <= ifri_pkg::MAX_VAL_RESET;
            color_reg  <= ifri_pkg::COLOR_RESET;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
            maxv_reg   <= maxv_next;
            color_reg  <= color_next;
        end
    end

    assign cfg.width     = ifri_pkg::clamp_dim(width_reg);
    assign cfg.height    = ifri_pkg::clamp_dim(height_reg);
    assign cfg.mode      = mode_reg;
    assign cfg.max_value = maxv_reg;
    assign cfg.color_rgb = color_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ifri_seq.sv
`default_nettype none

module ifri_seq (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ifri_pkg::ifri_cfg_t                cfg,
    input  wire logic                               restart,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic                               s_tuser,
    input  wire logic [3*ifri_pkg::FIELD_W-1:0]     s_tdata,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [3*ifri_pkg::FIELD_W-1:0]     m_tdata,
    output      logic                               m_tlast,
    output      logic                               ram_we,
    output      logic [ifri_pkg::ADDR_W-1:0]        ram_waddr,
    output      logic [ifri_pkg::PIX_W-1:0]         ram_wdata,
    output      logic                               ram_re,
    output      logic [ifri_pkg::ADDR_W-1:0]        ram_raddr,
    input  wire logic [ifri_pkg::PIX_W-1:0]         ram_rdata
);

    localparam int DW  = ifri_pkg::DIM_W;
    localparam int CB  = ifri_pkg::CHANNEL_BITS;
    localparam int FW  = ifri_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]                  st_reg, st_next;
    logic [ifri_pkg::LOAD_W-1:0] load_pos_reg, load_pos_next;
    logic [DW-1:0]               row_reg, row_next;
    logic [DW-1:0]               col_reg, col_next;
    logic [DW-1:0]               src_row_reg, src_col_reg;
    logic [DW-1:0]               src_row, src_col;
    logic                        last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [3*FW-1:0]             out_data_reg, out_data_next;
    logic                        out_last_reg;

    logic            rot;
    logic [DW-1:0]   out_w, out_h, eff_row, eff_col;
    logic [2*DW-1:0] total, lin_addr;
    logic            frame_full, wrap, is_last, s_fire, out_free, fetch_go;
    logic [CB-1:0]   rd_r, rd_g, rd_b, px_r, px_g, px_b;
    logic [FW-1:0]   inv_r, inv_g, inv_b;

    assign rot   = (cfg.mode == ifri_pkg::MODE_ROT_LEFT) || (cfg.mode == ifri_pkg::MODE_ROT_RIGHT);
    assign out_w = rot ? cfg.height : cfg.width;
    assign out_h = rot ? cfg.width : cfg.height;

    assign total      = (2*DW)'(cfg.width) * (2*DW)'(cfg.height);
    assign frame_full = (2*DW)'(load_pos_reg) >= total;

    // A mode change can leave the output position outside the new frame shape.
    assign wrap    = (row_reg >= out_h) || (col_reg >= out_w);
    assign eff_row = wrap ? '0 : row_reg;
    assign eff_col = wrap ? '0 : col_reg;
    assign is_last = (eff_row == out_h - DW'(1)) && (eff_col == out_w - DW'(1));

    always_comb begin
        case (cfg.mode)
            ifri_pkg::MODE_MIRROR_H: begin
                src_row = eff_row;
                src_col = cfg.width - DW'(1) - eff_col;
            end
            ifri_pkg::MODE_MIRROR_V: begin
                src_row = cfg.height - DW'(1) - eff_row;
                src_col = eff_col;
            end
            ifri_pkg::MODE_ROT_LEFT: begin
                src_row = eff_col;
                src_col = cfg.width - DW'(1) - eff_row;
            end
            ifri_pkg::MODE_ROT_RIGHT: begin
                src_row = cfg.height - DW'(1) - eff_col;
                src_col = eff_row;
            end
            default: begin
                src_row = eff_row;
                src_col = eff_col;
            end
        endcase
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign fetch_go = s_fire && (s_tuser == ifri_pkg::OP_FETCH) && frame_full;

    // Red lives in the top bits of a stored word, blue in the bottom.
    assign ram_we    = s_fire && (s_tuser == ifri_pkg::OP_LOAD) && !frame_full;
    assign ram_waddr = load_pos_reg[ifri_pkg::ADDR_W-1:0];
    assign ram_wdata = {s_tdata[CB-1:0], s_tdata[FW+CB-1:FW], s_tdata[2*FW+CB-1:2*FW]};

    assign lin_addr  = (2*DW)'(src_row_reg) * (2*DW)'(cfg.width) + (2*DW)'(src_col_reg);
    assign ram_re    = (st_reg == ST_ADDR);
    assign ram_raddr = lin_addr[ifri_pkg::ADDR_W-1:0];

    assign rd_r  = ram_rdata[ifri_pkg::PIX_W-1 -: CB];
    assign rd_g  = ram_rdata[2*CB-1 -: CB];
    assign rd_b  = ram_rdata[CB-1:0];
    assign inv_r = cfg.max_value - FW'(rd_r);
    assign inv_g = cfg.max_value - FW'(rd_g);
    assign inv_b = cfg.max_value - FW'(rd_b);

    always_comb begin
        if (cfg.mode == ifri_pkg::MODE_INVERT) begin
            px_r = inv_r[CB-1:0];
            px_g = inv_g[CB-1:0];
            px_b = inv_b[CB-1:0];
        end else begin
            px_r = rd_r;
            px_g = rd_g;
            px_b = rd_b;
        end
        if (!cfg.color_rgb) begin
            px_g = '0;
            px_b = '0;
        end
        out_data_next = {FW'(px_b), FW'(px_g), FW'(px_r)};
    end

    always_comb begin
        st_next        = st_reg;
        load_pos_next  = load_pos_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (st_reg)
            ST_IDLE: begin
                if (ram_we) begin
                    load_pos_next = load_pos_reg + ifri_pkg::LOAD_W'(1);
                end
                if (fetch_go) begin
                    st_next = ST_ADDR;
                    if (is_last) begin
                        load_pos_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                    end else if (eff_col == out_w - DW'(1)) begin
                        row_next = eff_row + DW'(1);
                        col_next = '0;
                    end else begin
                        row_next = eff_row;
                        col_next = eff_col + DW'(1);
                    end
                end
            end
            ST_ADDR: st_next = ST_READ;
            ST_READ: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
        if (restart) begin
            load_pos_next = '0;
            row_next      = '0;
            col_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            load_pos_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            load_pos_reg  <= load_pos_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_go) begin
            src_row_reg <= src_row;
            src_col_reg <= src_col;
            last_reg    <= is_last;
        end
        if ((st_reg == ST_READ) && out_free) begin
            out_data_reg <= out_data_next;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_load_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (2*DW)'(load_pos_reg) <= total)
        else $error("load count ran past the frame size");

    a_early_fetch_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_tuser == ifri_pkg::OP_FETCH) && !frame_full |=> st_reg == ST_IDLE)
        else $error("fetch before a full frame started a read");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_go && is_last |=> (load_pos_reg == '0) && (row_reg == '0) && (col_reg == '0))
        else $error("frame did not restart after its final pixel");

    a_read_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_READ) && out_free |=> out_valid_reg && (st_reg == ST_IDLE))
        else $error("read data was not moved to the output register");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [3*ifri_pkg::FIELD_W-1:0] s_tdata = '0;   // in_red, in_green, in_blue
    logic s_tuser = 1'b0;                           // operation
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*ifri_pkg::FIELD_W-1:0] m_tdata;        // out_red, out_green, out_blue
    logic m_tlast;                                  // last_pixel
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ifri_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ifri_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    image_flip_rotate_invert uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the orientation engine.
    logic [ifri_pkg::PIX_W-1:0]     frame_mem [0:ifri_pkg::STORE_DEPTH-1];
    int unsigned                    loaded_cnt = 0;
    int unsigned                    row_pos = 0;
    int unsigned                    col_pos = 0;
    logic [ifri_pkg::DIM_REG_W-1:0] width_reg = ifri_pkg::DIM_RESET;
    logic [ifri_pkg::DIM_REG_W-1:0] height_reg = ifri_pkg::DIM_RESET;
    logic [ifri_pkg::MODE_W-1:0]    mode_reg = ifri_pkg::MODE_RESET;
    logic [ifri_pkg::FIELD_W-1:0]   maxval_reg = ifri_pkg::MAX_VAL_RESET;
    logic                           rgb_reg = ifri_pkg::COLOR_RESET;

    pixel_word_t pixel_words [$];
    pixel_out_t  pixel_expect [$];

    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned pixels_loaded = 0;
    int unsigned pixels_predicted = 0;
    int unsigned pixels_checked = 0;
    int unsigned frames_done = 0;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic        s_took = 1'b0;
    logic        cfg_took = 1'b0;
    pixel_word_t next_word;
    pixel_word_t taken_word;
    pixel_out_t  predicted_px;
    pixel_out_t  oldest_px;
    bit          predicted_any;

    function automatic int unsigned dim_of(input logic [ifri_pkg::DIM_REG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > ifri_pkg::MAX_DIMENSION) return ifri_pkg::MAX_DIMENSION;
        return int'(raw);
    endfunction

    function automatic void apply_register(input logic [ifri_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [ifri_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            ifri_pkg::REG_IMAGE_WIDTH: begin
                width_reg = val[ifri_pkg::DIM_REG_W-1:0];
                loaded_cnt = 0;
                row_pos = 0;
                col_pos = 0;
            end
            ifri_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = val[ifri_pkg::DIM_REG_W-1:0];
                loaded_cnt = 0;
                row_pos = 0;
                col_pos = 0;
            end
            ifri_pkg::REG_TRANSFORM_MODE: mode_reg = val[ifri_pkg::MODE_W-1:0];
            ifri_pkg::REG_MAX_VALUE: maxval_reg = val[ifri_pkg::FIELD_W-1:0];
            ifri_pkg::REG_COLOR_MODE: rgb_reg = val[0];
            default: ;
        endcase
    endfunction

    function automatic void orient_step(input pixel_word_t word, output bit produced,
                                        output pixel_out_t px);
        int unsigned wd, ht, total, ow, oh, sr, sc;
        logic [7:0] r, g, b;
        bit is_last;
        wd = dim_of(width_reg);
        ht = dim_of(height_reg);
        total = wd * ht;
        produced = 1'b0;
        px = '0;
        if (word.op == ifri_pkg::OP_LOAD) begin
            if (loaded_cnt < total) begin
                frame_mem[loaded_cnt] = {word.red, word.green, word.blue};
                loaded_cnt++;
                pixels_loaded++;
            end
            return;
        end
        if (loaded_cnt < total) return;
        ow = wd;
        oh = ht;
        if (mode_reg == ifri_pkg::MODE_ROT_LEFT || mode_reg == ifri_pkg::MODE_ROT_RIGHT) begin
            ow = ht;
            oh = wd;
        end
        // A mode change mid-frame can leave the position outside the new shape.
        if (row_pos >= oh || col_pos >= ow) begin
            row_pos = 0;
            col_pos = 0;
        end
        case (mode_reg)
            ifri_pkg::MODE_MIRROR_H: begin
                sr = row_pos;
                sc = wd - 1 - col_pos;
            end
            ifri_pkg::MODE_MIRROR_V: begin
                sr = ht - 1 - row_pos;
                sc = col_pos;
            end
            ifri_pkg::MODE_ROT_LEFT: begin
                sr = col_pos;
                sc = wd - 1 - row_pos;
            end
            ifri_pkg::MODE_ROT_RIGHT: begin
                sr = ht - 1 - col_pos;
                sc = row_pos;
            end
            default: begin
                sr = row_pos;
                sc = col_pos;
            end
        endcase
        {r, g, b} = frame_mem[sr * wd + sc];
        if (mode_reg == ifri_pkg::MODE_INVERT) begin
            r = maxval_reg - r;
            g = maxval_reg - g;
            b = maxval_reg - b;
        end
        if (!rgb_reg) begin
            g = '0;
            b = '0;
        end
        is_last = (row_pos == oh - 1) && (col_pos == ow - 1);
        if (is_last) begin
            loaded_cnt = 0;
            row_pos = 0;
            col_pos = 0;
        end else if (col_pos == ow - 1) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        px.red = r;
        px.green = g;
        px.blue = b;
        px.last = is_last;
        produced = 1'b1;
        pixels_predicted++;
    endfunction

    task automatic flag_pixel(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endtask

    // Driver: words and receiver stalls change on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!s_tvalid || s_took) begin
                if (pixel_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = pixel_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_word.op;
                    s_tdata <= {next_word.blue, next_word.green, next_word.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: handshakes are sampled on the rising edge.
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pixel_expect.size() == 0) begin
                    flag_pixel($sformatf("unexpected pixel r=%02h g=%02h b=%02h last=%0b",
                        m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast));
                end else begin
                    oldest_px = pixel_expect.pop_front();
                    pixels_checked++;
                    if (oldest_px.last) frames_done++;
                    if (m_tdata[7:0] !== oldest_px.red || m_tdata[15:8] !== oldest_px.green ||
                        m_tdata[23:16] !== oldest_px.blue || m_tlast !== oldest_px.last) begin
                        flag_pixel($sformatf({"pixel mismatch: expected r=%02h g=%02h b=%02h ",
                            "last=%0b, got r=%02h g=%02h b=%02h last=%0b"},
                            oldest_px.red, oldest_px.green, oldest_px.blue, oldest_px.last,
                            m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                words_accepted++;
                taken_word.op = s_tuser;
                taken_word.red = s_tdata[7:0];
                taken_word.green = s_tdata[15:8];
                taken_word.blue = s_tdata[23:16];
                orient_step(taken_word, predicted_any, predicted_px);
                if (predicted_any) pixel_expect.insert(pixel_expect.size(), predicted_px);
            end
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
        end
    end

    task automatic write_reg(input logic [ifri_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ifri_pkg::CFG_DATA_W'(val);
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic queue_word(input logic op, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        pixel_word_t w;
        w.op = op;
        w.red = r;
        w.green = g;
        w.blue = b;
        pixel_words.insert(pixel_words.size(), w);
        words_queued++;
    endtask

    task automatic queue_random(input logic op, input int unsigned count);
        logic [31:0] rnd;
        repeat (count) begin
            rnd = $urandom;
            queue_word(op, rnd[7:0], rnd[15:8], rnd[23:16]);
        end
    endtask

    // Waits until every word is taken and every pixel has come back, then lets
    // the fetch pipeline settle before any register is touched.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (words_accepted != words_queued || pixel_expect.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int unsigned pick_dim();
        if ($urandom_range(0, 9) == 0) return 0;
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int unsigned total, to_load, n_fetch, done_items;
        bit big_row_done, big_col_done;
        big_row_done = 1'b0;
        big_col_done = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fetch into the empty default frame is dropped.
        start_phase(34, 67);
        queue_word(ifri_pkg::OP_FETCH, 8'hA5, 8'h5A, 8'h3C);
        wait_quiet();

        // 2x2 RGB inversion with extreme samples, an overfull load and a late fetch.
        write_reg(ifri_pkg::REG_IMAGE_WIDTH, 2);
        write_reg(ifri_pkg::REG_IMAGE_HEIGHT, 2);
        write_reg(ifri_pkg::REG_TRANSFORM_MODE, ifri_pkg::MODE_INVERT);
        write_reg(ifri_pkg::REG_MAX_VALUE, 255);
        write_reg(ifri_pkg::REG_COLOR_MODE, 1);
        start_phase(34, 67);
        queue_word(ifri_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00);
        queue_word(ifri_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
        queue_word(ifri_pkg::OP_LOAD, 8'hFF, 8'h00, 8'hAA);
        queue_word(ifri_pkg::OP_LOAD, 8'h00, 8'hFF, 8'h55);
        queue_word(ifri_pkg::OP_LOAD, 8'h12, 8'h34, 8'h56);
        queue_random(ifri_pkg::OP_FETCH, 5);
        wait_quiet();

        // Zero width acts as one; grayscale inversion that wraps below zero.
        write_reg(ifri_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(ifri_pkg::REG_IMAGE_HEIGHT, 3);
        write_reg(ifri_pkg::REG_MAX_VALUE, 1);
        write_reg(ifri_pkg::REG_COLOR_MODE, 0);
        start_phase(34, 67);
        queue_word(ifri_pkg::OP_LOAD, 8'h00, 8'hFF, 8'hFF);
        queue_word(ifri_pkg::OP_LOAD, 8'h01, 8'h80, 8'h01);
        queue_word(ifri_pkg::OP_LOAD, 8'hFE, 8'h7F, 8'hFE);
        queue_random(ifri_pkg::OP_FETCH, 3);
        wait_quiet();

        // Unused mode code, then a height write that throws away a partial frame.
        write_reg(ifri_pkg::REG_TRANSFORM_MODE, 7);
        start_phase(34, 67);
        queue_random(ifri_pkg::OP_LOAD, 2);
        wait_quiet();
        write_reg(ifri_pkg::REG_IMAGE_HEIGHT, 2);
        start_phase(34, 67);
        queue_random(ifri_pkg::OP_LOAD, 2);
        queue_random(ifri_pkg::OP_FETCH, 2);
        wait_quiet();

        done_items = words_queued;
        while (done_items < 1650) begin
            n_fetch = 0;
            if (!big_row_done && done_items > 300) begin
                write_reg(ifri_pkg::REG_IMAGE_WIDTH, 256);
                write_reg(ifri_pkg::REG_IMAGE_HEIGHT, 1);
                write_reg(ifri_pkg::REG_TRANSFORM_MODE, $urandom_range(0, 4));
                big_row_done = 1'b1;
            end else if (!big_col_done && done_items > 900) begin
                // Oversized height clamps to the maximum; only part of it is read out.
                write_reg(ifri_pkg::REG_IMAGE_WIDTH, 1);
                write_reg(ifri_pkg::REG_IMAGE_HEIGHT, 511);
                big_col_done = 1'b1;
                n_fetch = 40;
            end else begin
                if ($urandom_range(0, 9) < 6) begin
                    write_reg(ifri_pkg::REG_IMAGE_WIDTH, pick_dim());
                    write_reg(ifri_pkg::REG_IMAGE_HEIGHT, pick_dim());
                end
                if ($urandom_range(0, 1) == 1) begin
                    if ($urandom_range(0, 9) == 0)
                        write_reg(ifri_pkg::REG_TRANSFORM_MODE, $urandom_range(5, 7));
                    else
                        write_reg(ifri_pkg::REG_TRANSFORM_MODE, $urandom_range(0, 4));
                end
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0: write_reg(ifri_pkg::REG_MAX_VALUE, 1);
                        1: write_reg(ifri_pkg::REG_MAX_VALUE, 255);
                        default: write_reg(ifri_pkg::REG_MAX_VALUE, $urandom_range(1, 255));
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    write_reg(ifri_pkg::REG_COLOR_MODE, $urandom_range(0, 1));
            end

            if (done_items < 600) start_phase(34, 67);
            else if (done_items < 1200) start_phase(67, 34);
            else start_phase(0, 0);

            total = dim_of(width_reg) * dim_of(height_reg);
            to_load = total - loaded_cnt;
            repeat (to_load) begin
                // An occasional early fetch must be dropped.
                if ($urandom_range(0, 19) == 0) queue_random(ifri_pkg::OP_FETCH, 1);
                queue_random(ifri_pkg::OP_LOAD, 1);
            end
            if ($urandom_range(0, 4) == 0)
                queue_random(ifri_pkg::OP_LOAD, $urandom_range(1, 2));
            if (n_fetch == 0) begin
                if ($urandom_range(0, 5) == 0 && total > 1) n_fetch = $urandom_range(1, total - 1);
                else n_fetch = total;
            end
            queue_random(ifri_pkg::OP_FETCH, n_fetch);
            if ($urandom_range(0, 7) == 0) queue_random(ifri_pkg::OP_FETCH, 1);
            wait_quiet();
            done_items = words_queued;
        end

        wait_quiet();
        $display("Checked %0d output pixels in %0d completed frames after %0d pixel loads.",
                 pixels_checked, frames_done, pixels_loaded);
        $display("Frames ranged from 1x1 to 256 on a side over all mode codes and both color modes.");
        if (mismatches == 0 && pixel_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/ifri_pkg.sv
hw/rtl/ifri_ram.sv
hw/rtl/ifri_regs.sv
hw/rtl/ifri_seq.sv
hw/rtl/image_flip_rotate_invert.sv
tb/sv/testbench.sv
